// ----- src/tsu_pkg.sv -----
`timescale 1ns / 1ps
package tsu_pkg;

  localparam int TASKS      = 64;
  localparam int HEAP_DEPTH = 64;
  localparam int TIME_WIDTH = 32;
  localparam int TID_W      = 6;
  localparam int HIDX_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = HIDX_W + 1;
  localparam int LOC_W      = 2;
  localparam int OP_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PARK    = 3'd0,
    OP_EXPIRE  = 3'd1,
    OP_POP     = 3'd2,
    OP_CANCEL  = 3'd3,
    OP_RELEASE = 3'd4
  } op_e;

  typedef enum logic [LOC_W-1:0] {
    LOC_IDLE  = 2'd0,
    LOC_READY = 2'd1,
    LOC_TIMER = 2'd2
  } loc_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_RM_START,
    ST_RM_LAST,
    ST_DN_START,
    ST_DN_L,
    ST_DN_R,
    ST_DN_DEC,
    ST_UP_START,
    ST_UP_CHK,
    ST_PLACE,
    ST_RQPUSH,
    ST_POP_NX,
    ST_UL_RD,
    ST_UL_CHK,
    ST_DONE
  } state_e;

  // One heap slot: deadline and owning task.
  typedef struct packed {
    logic [TIME_WIDTH-1:0] dl;
    logic [TID_W-1:0]      tid;
  } hent_t;

  typedef struct packed {
    logic              we;
    logic [HIDX_W-1:0] waddr;
    hent_t             wdata;
    logic [HIDX_W-1:0] raddr;
  } hp_req_t;

  typedef struct packed {
    logic              we;
    logic [TID_W-1:0]  waddr;
    logic [HIDX_W-1:0] wdata;
    logic [TID_W-1:0]  raddr;
  } pos_req_t;

  typedef struct packed {
    logic             we;
    logic [TID_W-1:0] waddr;
    logic [TID_W-1:0] wdata;
    logic [TID_W-1:0] raddr;
  } nxt_req_t;

  typedef struct packed {
    logic             we;
    logic [TID_W-1:0] waddr;
    logic [LOC_W-1:0] wdata;
    logic [TID_W-1:0] raddr;
  } loc_req_t;

endpackage

// ----- src/tsu_ram.sv -----
`timescale 1ns / 1ps
module tsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tsu_cmp.sv -----
`timescale 1ns / 1ps
module tsu_cmp
  import tsu_pkg::*;
(
  input  hent_t a_i,
  input  hent_t b_i,
  output logic  lt_o,
  output hent_t min_o
);

  // Strict compare on deadlines; ties keep the second operand.
  assign lt_o  = a_i.dl < b_i.dl;
  assign min_o = lt_o ? a_i : b_i;

endmodule

// ----- src/tsu_seq.sv -----
`timescale 1ns / 1ps
module tsu_seq
  import tsu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [TID_W-1:0]      task_id_i,
  input  logic [TIME_WIDTH-1:0] deadline_ms_i,
  input  logic [TIME_WIDTH-1:0] now_ms_i,
  input  logic                  task_failed_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [TID_W-1:0]      result_task_o,
  output logic                  result_valid_o,
  output logic [LOC_W-1:0]      task_place_o,
  output logic [CNT_W-1:0]      expired_count_o,
  output logic [CNT_W-1:0]      timers_waiting_o,
  output logic                  heap_full_o,
  output hp_req_t               hp_req_o,
  input  hent_t                 hp_rdata_i,
  output pos_req_t              pos_req_o,
  input  logic [HIDX_W-1:0]     pos_rdata_i,
  output nxt_req_t              nxt_req_o,
  input  logic [TID_W-1:0]      nxt_rdata_i,
  output loc_req_t              loc_req_o,
  input  logic [LOC_W-1:0]      loc_rdata_i,
  output hent_t                 cmp_a_o,
  output hent_t                 cmp_b_o,
  input  logic                  cmp_lt_i,
  input  hent_t                 cmp_min_i
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [TID_W-1:0] head_q, head_d, tail_q, tail_d;
  logic ne_q, ne_d;
  logic [TASKS-1:0] loc_vld_q;
  logic out_valid_q, out_valid_d, out_load;

  logic [OP_W-1:0] op_q, op_d;
  logic [TID_W-1:0] tid_q, tid_d;
  logic [TIME_WIDTH-1:0] dl_q, dl_d, now_q, now_d;
  logic failed_q, failed_d, hit_q, hit_d;
  hent_t x_q, x_d, best_q, best_d;
  logic [HIDX_W-1:0] i_q, i_d, m_q, m_d;
  logic moved_q, moved_d;
  logic [TID_W-1:0] tpush_q, tpush_d, cur_q, cur_d, prev_q, prev_d;
  logic hasprev_q, hasprev_d;
  logic [TID_W-1:0] restask_q, restask_d;
  logic valid_q, valid_d, full_q, full_d;
  logic [LOC_W-1:0] place_q, place_d;
  logic [CNT_W-1:0] exp_q, exp_d;

  logic [TID_W-1:0] ores_task_q;
  logic ores_valid_q, ofull_q;
  logic [LOC_W-1:0] oplace_q;
  logic [CNT_W-1:0] oexp_q, owait_q;

  logic [LOC_W-1:0] loc_cur;
  logic [CNT_W-1:0] lidx, cnt_m1;
  logic [CNT_W:0] ridx;
  logic [HIDX_W-1:0] i_m1, parent;
  logic wants;
  state_e post_rm;

  assign loc_cur = hit_q ? loc_rdata_i : LOC_IDLE;
  assign lidx    = {i_q, 1'b1};
  assign ridx    = {1'b0, lidx} + 1'b1;
  assign cnt_m1  = cnt_q - 1'b1;
  assign i_m1    = i_q - 1'b1;
  assign parent  = {1'b0, i_m1[HIDX_W-1:1]};
  assign wants   = !failed_q && !cmp_lt_i;
  assign post_rm = (op_q == OP_RELEASE) ? ST_DONE : ST_RQPUSH;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ne_d        = ne_q;
    op_d        = op_q;
    tid_d       = tid_q;
    dl_d        = dl_q;
    now_d       = now_q;
    failed_d    = failed_q;
    hit_d       = hit_q;
    x_d         = x_q;
    best_d      = best_q;
    i_d         = i_q;
    m_d         = m_q;
    moved_d     = moved_q;
    tpush_d     = tpush_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    hasprev_d   = hasprev_q;
    restask_d   = restask_q;
    valid_d     = valid_q;
    full_d      = full_q;
    place_d     = place_q;
    exp_d       = exp_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = (state_q != ST_IDLE);
    hp_req_o    = '0;
    pos_req_o   = '0;
    nxt_req_o   = '0;
    loc_req_o   = '0;
    cmp_a_o     = hp_rdata_i;
    cmp_b_o     = best_q;

    case (state_q)
      ST_IDLE: begin
        loc_req_o.raddr = task_id_i;
        pos_req_o.raddr = task_id_i;
        if (in_valid_i) begin
          op_d      = operation_i;
          tid_d     = task_id_i;
          dl_d      = deadline_ms_i;
          now_d     = now_ms_i;
          failed_d  = task_failed_i;
          hit_d     = loc_vld_q[task_id_i];
          restask_d = task_id_i;
          valid_d   = 1'b0;
          full_d    = 1'b0;
          place_d   = LOC_IDLE;
          exp_d     = '0;
          state_d   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmp_a_o = '{dl: dl_q, tid: tid_q};
        cmp_b_o = '{dl: now_q, tid: tid_q};
        case (op_q)
          OP_PARK: begin
            if (loc_cur == LOC_IDLE) begin
              valid_d = 1'b1;
              if (wants && cnt_q < CNT_W'(HEAP_DEPTH)) begin
                cnt_d           = cnt_q + 1'b1;
                x_d             = '{dl: dl_q, tid: tid_q};
                i_d             = cnt_q[HIDX_W-1:0];
                loc_req_o.we    = 1'b1;
                loc_req_o.waddr = tid_q;
                loc_req_o.wdata = LOC_TIMER;
                place_d         = LOC_TIMER;
                state_d         = ST_UP_START;
              end else begin
                full_d  = wants;
                tpush_d = tid_q;
                place_d = LOC_READY;
                state_d = ST_RQPUSH;
              end
            end else begin
              place_d = loc_cur;
              state_d = ST_DONE;
            end
          end
          OP_EXPIRE: begin
            valid_d   = 1'b1;
            restask_d = '0;
            state_d   = ST_EXP_RD;
          end
          OP_POP: begin
            restask_d = '0;
            state_d   = ST_DONE;
            if (ne_q) begin
              restask_d       = head_q;
              valid_d         = 1'b1;
              loc_req_o.we    = 1'b1;
              loc_req_o.waddr = head_q;
              loc_req_o.wdata = LOC_IDLE;
              if (head_q == tail_q) begin
                ne_d = 1'b0;
              end else begin
                nxt_req_o.raddr = head_q;
                state_d         = ST_POP_NX;
              end
            end
          end
          OP_CANCEL: begin
            if (loc_cur == LOC_TIMER) begin
              valid_d = 1'b1;
              tpush_d = tid_q;
              i_d     = pos_rdata_i;
              place_d = LOC_READY;
              state_d = ST_RM_START;
            end else begin
              place_d = loc_cur;
              state_d = ST_DONE;
            end
          end
          OP_RELEASE: begin
            loc_req_o.we    = 1'b1;
            loc_req_o.waddr = tid_q;
            loc_req_o.wdata = LOC_IDLE;
            state_d         = ST_DONE;
            if (loc_cur == LOC_TIMER) begin
              valid_d = 1'b1;
              i_d     = pos_rdata_i;
              state_d = ST_RM_START;
            end else if (loc_cur == LOC_READY) begin
              valid_d   = 1'b1;
              cur_d     = head_q;
              hasprev_d = 1'b0;
              if (ne_q) begin
                state_d = ST_UL_RD;
              end
            end
          end
          default: begin
            place_d = loc_cur;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_EXP_RD: begin
        hp_req_o.raddr = '0;
        state_d = (cnt_q == '0) ? ST_DONE : ST_EXP_CHK;
      end
      ST_EXP_CHK: begin
        cmp_a_o = hp_rdata_i;
        cmp_b_o = '{dl: now_q, tid: hp_rdata_i.tid};
        if (cmp_lt_i) begin
          tpush_d = hp_rdata_i.tid;
          exp_d   = exp_q + 1'b1;
          i_d     = '0;
          state_d = ST_RM_START;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RM_START: begin
        if ({1'b0, i_q} >= cnt_q) begin
          state_d = post_rm;
        end else begin
          cnt_d = cnt_m1;
          if ({1'b0, i_q} == cnt_m1) begin
            state_d = post_rm;
          end else begin
            hp_req_o.raddr = cnt_m1[HIDX_W-1:0];
            state_d        = ST_RM_LAST;
          end
        end
      end
      ST_RM_LAST: begin
        x_d     = hp_rdata_i;
        moved_d = 1'b0;
        state_d = ST_DN_START;
      end
      ST_DN_START: begin
        m_d    = i_q;
        best_d = x_q;
        if (lidx < cnt_q) begin
          hp_req_o.raddr = lidx[HIDX_W-1:0];
          state_d        = ST_DN_L;
        end else begin
          state_d = ST_DN_DEC;
        end
      end
      ST_DN_L: begin
        if (cmp_lt_i) begin
          best_d = cmp_min_i;
          m_d    = lidx[HIDX_W-1:0];
        end
        if (ridx < {1'b0, cnt_q}) begin
          hp_req_o.raddr = ridx[HIDX_W-1:0];
          state_d        = ST_DN_R;
        end else begin
          state_d = ST_DN_DEC;
        end
      end
      ST_DN_R: begin
        if (cmp_lt_i) begin
          best_d = cmp_min_i;
          m_d    = ridx[HIDX_W-1:0];
        end
        state_d = ST_DN_DEC;
      end
      ST_DN_DEC: begin
        if (m_q == i_q) begin
          state_d = moved_q ? ST_PLACE : ST_UP_START;
        end else begin
          hp_req_o.we     = 1'b1;
          hp_req_o.waddr  = i_q;
          hp_req_o.wdata  = best_q;
          pos_req_o.we    = 1'b1;
          pos_req_o.waddr = best_q.tid;
          pos_req_o.wdata = i_q;
          i_d             = m_q;
          moved_d         = 1'b1;
          state_d         = ST_DN_START;
        end
      end
      ST_UP_START: begin
        if (i_q == '0) begin
          state_d = ST_PLACE;
        end else begin
          hp_req_o.raddr = parent;
          state_d        = ST_UP_CHK;
        end
      end
      ST_UP_CHK: begin
        cmp_a_o = x_q;
        cmp_b_o = hp_rdata_i;
        if (cmp_lt_i) begin
          hp_req_o.we     = 1'b1;
          hp_req_o.waddr  = i_q;
          hp_req_o.wdata  = hp_rdata_i;
          pos_req_o.we    = 1'b1;
          pos_req_o.waddr = hp_rdata_i.tid;
          pos_req_o.wdata = i_q;
          i_d             = parent;
          state_d         = ST_UP_START;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        hp_req_o.we     = 1'b1;
        hp_req_o.waddr  = i_q;
        hp_req_o.wdata  = x_q;
        pos_req_o.we    = 1'b1;
        pos_req_o.waddr = x_q.tid;
        pos_req_o.wdata = i_q;
        state_d         = (op_q == OP_PARK) ? ST_DONE : post_rm;
      end
      ST_RQPUSH: begin
        loc_req_o.we    = 1'b1;
        loc_req_o.waddr = tpush_q;
        loc_req_o.wdata = LOC_READY;
        if (ne_q) begin
          nxt_req_o.we    = 1'b1;
          nxt_req_o.waddr = tail_q;
          nxt_req_o.wdata = tpush_q;
        end else begin
          head_d = tpush_q;
        end
        tail_d  = tpush_q;
        ne_d    = 1'b1;
        state_d = (op_q == OP_EXPIRE) ? ST_EXP_RD : ST_DONE;
      end
      ST_POP_NX: begin
        head_d  = nxt_rdata_i;
        state_d = ST_DONE;
      end
      ST_UL_RD: begin
        nxt_req_o.raddr = cur_q;
        state_d         = ST_UL_CHK;
      end
      ST_UL_CHK: begin
        state_d = ST_DONE;
        if (cur_q == tid_q) begin
          if (cur_q == tail_q) begin
            if (hasprev_q) begin
              tail_d = prev_q;
            end else begin
              ne_d = 1'b0;
            end
          end else if (hasprev_q) begin
            nxt_req_o.we    = 1'b1;
            nxt_req_o.waddr = prev_q;
            nxt_req_o.wdata = nxt_rdata_i;
          end else begin
            head_d = nxt_rdata_i;
          end
        end else if (cur_q != tail_q) begin
          prev_d    = cur_q;
          hasprev_d = 1'b1;
          cur_d     = nxt_rdata_i;
          state_d   = ST_UL_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      ne_q        <= 1'b0;
      loc_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      ne_q        <= ne_d;
      out_valid_q <= out_valid_d;
      if (loc_req_o.we) begin
        loc_vld_q[loc_req_o.waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    tid_q     <= tid_d;
    dl_q      <= dl_d;
    now_q     <= now_d;
    failed_q  <= failed_d;
    hit_q     <= hit_d;
    x_q       <= x_d;
    best_q    <= best_d;
    i_q       <= i_d;
    m_q       <= m_d;
    moved_q   <= moved_d;
    tpush_q   <= tpush_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    hasprev_q <= hasprev_d;
    restask_q <= restask_d;
    valid_q   <= valid_d;
    full_q    <= full_d;
    place_q   <= place_d;
    exp_q     <= exp_d;
    if (out_load) begin
      ores_task_q  <= restask_q;
      ores_valid_q <= valid_q;
      oplace_q     <= place_q;
      oexp_q       <= exp_q;
      owait_q      <= cnt_q;
      ofull_q      <= full_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_task_o    = ores_task_q;
  assign result_valid_o   = ores_valid_q;
  assign task_place_o     = oplace_q;
  assign expired_count_o  = oexp_q;
  assign timers_waiting_o = owait_q;
  assign heap_full_o      = ofull_q;

endmodule

// ----- src/timer_heap_task_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o    operation, task_id, deadline_ms, now_ms,
//                                               task_failed
// out       output     out_valid_o/out_stall_i  result_task, result_valid, task_place,
//                                               expired_count, timers_waiting, heap_full
//
// One transaction is worked at a time by a sequencer around a single deadline comparator.
// Pop reads the next link of the ready list and most misses go straight to the result; park
// sifts the new timer up the heap; cancel and release of a timer move the last heap slot into
// the hole and sift it down or up, and release from the ready list walks it one task at a time.
// Expire takes each timer whose deadline is before now from the root and puts it on the ready
// list, one timer after another. Reset is asynchronous and active low; every task starts idle
// with no clearing pass. A result waiting under out_stall_i holds the block only at its next finish.
module timer_heap_task_scheduler_unit
  import tsu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [TID_W-1:0]      task_id_i,
  input  logic [TIME_WIDTH-1:0] deadline_ms_i,
  input  logic [TIME_WIDTH-1:0] now_ms_i,
  input  logic                  task_failed_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [TID_W-1:0]      result_task_o,
  output logic                  result_valid_o,
  output logic [LOC_W-1:0]      task_place_o,
  output logic [CNT_W-1:0]      expired_count_o,
  output logic [CNT_W-1:0]      timers_waiting_o,
  output logic                  heap_full_o
);

  // Memory request and response groups between the sequencer and the stores.
  hp_req_t  hp_req;
  pos_req_t pos_req;
  nxt_req_t nxt_req;
  loc_req_t loc_req;
  hent_t    hp_rdata;
  logic [HIDX_W-1:0] pos_rdata;
  logic [TID_W-1:0]  nxt_rdata;
  logic [LOC_W-1:0]  loc_rdata;
  logic [$bits(hent_t)-1:0] hp_rdata_raw;

  // Shared comparator operands and results.
  hent_t cmp_a, cmp_b, cmp_min;
  logic  cmp_lt;

  assign hp_rdata = hent_t'(hp_rdata_raw);

  // Timer heap slots: deadline plus owning task.
  tsu_ram #(.WIDTH($bits(hent_t)), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (hp_req.we),
    .waddr_i (hp_req.waddr),
    .wdata_i (hp_req.wdata),
    .raddr_i (hp_req.raddr),
    .rdata_o (hp_rdata_raw)
  );

  // Heap slot of each task on a timer.
  tsu_ram #(.WIDTH(HIDX_W), .DEPTH(TASKS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_req.we),
    .waddr_i (pos_req.waddr),
    .wdata_i (pos_req.wdata),
    .raddr_i (pos_req.raddr),
    .rdata_o (pos_rdata)
  );

  // Ready list links.
  tsu_ram #(.WIDTH(TID_W), .DEPTH(TASKS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_req.we),
    .waddr_i (nxt_req.waddr),
    .wdata_i (nxt_req.wdata),
    .raddr_i (nxt_req.raddr),
    .rdata_o (nxt_rdata)
  );

  // Task location; entries never written read as idle through valid bits in the sequencer.
  tsu_ram #(.WIDTH(LOC_W), .DEPTH(TASKS)) u_loc_ram (
    .clk_i   (clk_i),
    .we_i    (loc_req.we),
    .waddr_i (loc_req.waddr),
    .wdata_i (loc_req.wdata),
    .raddr_i (loc_req.raddr),
    .rdata_o (loc_rdata)
  );

  tsu_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .lt_o  (cmp_lt),
    .min_o (cmp_min)
  );

  tsu_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .task_id_i        (task_id_i),
    .deadline_ms_i    (deadline_ms_i),
    .now_ms_i         (now_ms_i),
    .task_failed_i    (task_failed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_task_o    (result_task_o),
    .result_valid_o   (result_valid_o),
    .task_place_o     (task_place_o),
    .expired_count_o  (expired_count_o),
    .timers_waiting_o (timers_waiting_o),
    .heap_full_o      (heap_full_o),
    .hp_req_o         (hp_req),
    .hp_rdata_i       (hp_rdata),
    .pos_req_o        (pos_req),
    .pos_rdata_i      (pos_rdata),
    .nxt_req_o        (nxt_req),
    .nxt_rdata_i      (nxt_rdata),
    .loc_req_o        (loc_req),
    .loc_rdata_i      (loc_rdata),
    .cmp_a_o          (cmp_a),
    .cmp_b_o          (cmp_b),
    .cmp_lt_i         (cmp_lt),
    .cmp_min_i        (cmp_min)
  );

endmodule
